// ===== rtl/core/dsvs_pkg.sv =====
// ----------------------------------------------------------------------------
// dsvs_pkg
// Shared types and constants of the decaying sine voice synthesizer.
// ----------------------------------------------------------------------------
package dsvs_pkg;

    // default parameter values
    localparam int VOICES_DEF       = 14;
    localparam int PHASE_BITS_DEF   = 24;
    localparam int SINE_ENTRIES_DEF = 1024;

    // fixed field widths
    localparam int VOL_W    = 28;
    localparam int DECAY_W  = 16;
    localparam int KEY_W    = 8;
    localparam int VIDX_W   = 4;
    localparam int STEP_W   = 24;
    localparam int SAMPLE_W = 32;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    // shared multiplier operand widths
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_STRIKE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE = 2'd2;

    // configuration reset values
    localparam logic [DECAY_W-1:0] DECAY_RST  = 16'd65503;
    localparam logic [VOL_W-1:0]   FLOOR_RST  = 28'h09D89D8;
    localparam logic [VOL_W-1:0]   STRIKE_RST = 28'h9D89D89;

    // key code map
    localparam logic [KEY_W-1:0] KEY_LO_A   = 8'd3;
    localparam logic [KEY_W-1:0] KEY_HI_A   = 8'd8;
    localparam logic [KEY_W-1:0] KEY_SKIP   = 8'd5;
    localparam logic [KEY_W-1:0] KEY_LO_B   = 8'd16;
    localparam logic [KEY_W-1:0] KEY_HI_B   = 8'd23;
    localparam logic [KEY_W-1:0] KEY_OFS_B  = 8'd10;

    // sine polynomial, Q14 argument
    localparam logic [15:0] Q_ONE    = 16'd16384;
    localparam logic [15:0] POLY_C0  = 16'd153;
    localparam logic [15:0] POLY_C1  = 16'd2611;
    localparam logic [15:0] POLY_C2  = 16'd21167;
    localparam logic [15:0] POLY_C3  = 16'd51472;
    localparam logic [15:0] SINE_MAX = 16'd32767;

    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [VIDX_W-1:0] vidx;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic [DECAY_W-1:0] decay;
        logic [VOL_W-1:0]   floor_lvl;
        logic [VOL_W-1:0]   strike;
    } t_cfg;

    typedef struct packed {
        logic                busy;
        logic                smp_valid;
        logic [SAMPLE_W-1:0] sample;
    } t_stat;

endpackage

// ===== rtl/core/decaying_sine_voice_synth.sv =====
// ----------------------------------------------------------------------------
// decaying_sine_voice_synth
// Additive sine synthesizer with per-voice exponential decay.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata: key, voice, step; tuser: opcode
// m_axis    out  m_axis_tvalid/tready         tdata: mixed sample
// cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// Strike and load words are applied on accept, without leaving idle. A tick
// runs eight steps per voice, seven of them on one 28x16 multiplier, then
// a done state hands off the sample.
// Reset is synchronous; volumes, phases and steps clear at once.
// A finished sample waits in the output register; the next tick may run
// while it waits and then holds in its last state until the register frees.
// ----------------------------------------------------------------------------
module decaying_sine_voice_synth #(
    parameter int VOICES       = dsvs_pkg::VOICES_DEF,
    parameter int PHASE_BITS   = dsvs_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = dsvs_pkg::SINE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [27:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // key_code[7:0], voice_index[11:8], phase_step[35:12]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // sample_value[31:0]
);

    logic [dsvs_pkg::DECAY_W-1:0] r_decay;
    logic [dsvs_pkg::VOL_W-1:0]   r_floor;
    logic [dsvs_pkg::VOL_W-1:0]   r_strike;
    logic                         r_ov;
    logic [31:0]                  r_odata;

    dsvs_pkg::t_cmd  cmd;
    dsvs_pkg::t_cfg  cfg;
    dsvs_pkg::t_stat stat;
    logic            smp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= dsvs_pkg::DECAY_RST;
            r_floor  <= dsvs_pkg::FLOOR_RST;
            r_strike <= dsvs_pkg::STRIKE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsvs_pkg::CFG_DECAY:  r_decay  <= i_cfg_data[15:0];
                dsvs_pkg::CFG_FLOOR:  r_floor  <= i_cfg_data;
                dsvs_pkg::CFG_STRIKE: r_strike <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.decay     = r_decay;
    assign cfg.floor_lvl = r_floor;
    assign cfg.strike    = r_strike;

    assign s_axis_tready = !stat.busy;
    assign cmd.valid     = s_axis_tvalid && !stat.busy;
    assign cmd.op        = s_axis_tuser;
    assign cmd.key       = s_axis_tdata[7:0];
    assign cmd.vidx      = s_axis_tdata[11:8];
    assign cmd.step      = s_axis_tdata[35:12];

    assign smp_ready = !r_ov || m_axis_tready;

    dsvs_core #(
        .VOICES       (VOICES),
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_smp_ready (smp_ready),
        .o_stat      (stat)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (stat.smp_valid && smp_ready) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.smp_valid && smp_ready) begin
            r_odata <= stat.sample;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== rtl/core/dsvs_mul.sv =====
// ----------------------------------------------------------------------------
// dsvs_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dsvs_mul #(
    parameter int A_W = dsvs_pkg::MUL_A_W,
    parameter int B_W = dsvs_pkg::MUL_B_W
) (
    input  logic             i_clk,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [A_W+B_W-1:0] o_prod
);

    logic [A_W+B_W-1:0] r_prod;
    logic [A_W+B_W-1:0] n_prod;

    assign n_prod = (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/dsvs_core.sv =====
// ----------------------------------------------------------------------------
// dsvs_core
// Voice state and sequencer: walks the voices through the shared multiplier,
// eight passes per voice (sine polynomial, level, decay, writeback).
// ----------------------------------------------------------------------------
module dsvs_core #(
    parameter int VOICES       = dsvs_pkg::VOICES_DEF,
    parameter int PHASE_BITS   = dsvs_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = dsvs_pkg::SINE_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsvs_pkg::t_cmd  i_cmd,
    input  dsvs_pkg::t_cfg  i_cfg,
    input  logic            i_smp_ready,
    output dsvs_pkg::t_stat o_stat
);

    localparam int VI_W  = $clog2(VOICES);
    localparam int LOG2E = $clog2(SINE_ENTRIES);
    localparam int ACC_W = dsvs_pkg::VOL_W + $clog2(VOICES) + 1;
    localparam int VW    = dsvs_pkg::VOL_W;
    localparam int PW    = dsvs_pkg::MUL_A_W + dsvs_pkg::MUL_B_W;
    localparam logic [VI_W-1:0] LAST_V = VI_W'(VOICES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] STP_SQ    = 3'd0;
    localparam logic [2:0] STP_P1    = 3'd1;
    localparam logic [2:0] STP_P2    = 3'd2;
    localparam logic [2:0] STP_P3    = 3'd3;
    localparam logic [2:0] STP_SX    = 3'd4;
    localparam logic [2:0] STP_LVL   = 3'd5;
    localparam logic [2:0] STP_DECAY = 3'd6;
    localparam logic [2:0] STP_WB    = 3'd7;

    logic [VW-1:0]         r_vol [VOICES];
    logic [PHASE_BITS-1:0] r_ph  [VOICES];
    logic [PHASE_BITS-1:0] r_st  [VOICES];

    logic [1:0]              r_state;
    logic [2:0]              r_stp;
    logic [VI_W-1:0]         r_vc;
    logic signed [ACC_W-1:0] r_acc;
    logic [14:0]             r_x;
    logic [14:0]             r_x2;
    logic                    r_neg;

    logic [VW-1:0]         cur_vol;
    logic [PHASE_BITS-1:0] cur_ph;
    logic [PHASE_BITS-1:0] cur_st;
    logic [LOG2E-1:0]      k;
    logic [15:0]           t;
    logic [14:0]           x;
    logic [PW-1:0]         prod;
    logic [15:0]           q14;
    logic [14:0]           s;
    logic [VW-1:0]         term;
    logic signed [ACC_W-1:0] term_s;
    logic [VW-1:0]         nv;
    logic [dsvs_pkg::MUL_A_W-1:0] mul_a;
    logic [dsvs_pkg::MUL_B_W-1:0] mul_b;

    logic [dsvs_pkg::KEY_W-1:0] key_v;
    logic                       key_hit;
    logic                       load_hit;
    logic signed [63:0]         acc64;
    logic [dsvs_pkg::SAMPLE_W-1:0] sat;

    assign cur_vol = r_vol[r_vc];
    assign cur_ph  = r_ph[r_vc];
    assign cur_st  = r_st[r_vc];

    // table index, then Q16 turn
    assign k = cur_ph[PHASE_BITS-1 -: LOG2E];
    assign t = {k, (16-LOG2E)'(0)};
    assign x = t[14] ? 15'(dsvs_pkg::Q_ONE - {2'b00, t[13:0]}) : {1'b0, t[13:0]};

    assign q14    = prod[29:14];
    assign s      = (q14 > dsvs_pkg::SINE_MAX) ? dsvs_pkg::SINE_MAX[14:0] : q14[14:0];
    assign term   = prod[42:15];
    assign term_s = $signed(ACC_W'(term));
    assign nv     = prod[43:16];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_stp)
            STP_SQ: begin
                mul_a = dsvs_pkg::MUL_A_W'(x);
                mul_b = dsvs_pkg::MUL_B_W'(x);
            end
            STP_P1: begin
                mul_a = dsvs_pkg::MUL_A_W'(dsvs_pkg::POLY_C0);
                mul_b = dsvs_pkg::MUL_B_W'(q14[14:0]);
            end
            STP_P2: begin
                mul_a = dsvs_pkg::MUL_A_W'(dsvs_pkg::POLY_C1 - q14);
                mul_b = dsvs_pkg::MUL_B_W'(r_x2);
            end
            STP_P3: begin
                mul_a = dsvs_pkg::MUL_A_W'(dsvs_pkg::POLY_C2 - q14);
                mul_b = dsvs_pkg::MUL_B_W'(r_x2);
            end
            STP_SX: begin
                mul_a = dsvs_pkg::MUL_A_W'(dsvs_pkg::POLY_C3 - q14);
                mul_b = dsvs_pkg::MUL_B_W'(r_x);
            end
            STP_LVL: begin
                mul_a = dsvs_pkg::MUL_A_W'(cur_vol);
                mul_b = dsvs_pkg::MUL_B_W'(s);
            end
            STP_DECAY: begin
                mul_a = dsvs_pkg::MUL_A_W'(cur_vol);
                mul_b = dsvs_pkg::MUL_B_W'(i_cfg.decay);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dsvs_mul #(
        .A_W (dsvs_pkg::MUL_A_W),
        .B_W (dsvs_pkg::MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // key code to voice
    always_comb begin
        key_v   = '0;
        key_hit = 1'b0;
        if (i_cmd.key >= dsvs_pkg::KEY_LO_A && i_cmd.key <= dsvs_pkg::KEY_HI_A &&
            i_cmd.key != dsvs_pkg::KEY_SKIP) begin
            key_v   = i_cmd.key - dsvs_pkg::KEY_LO_A;
            key_hit = 1'b1;
        end else if (i_cmd.key >= dsvs_pkg::KEY_LO_B && i_cmd.key <= dsvs_pkg::KEY_HI_B) begin
            key_v   = i_cmd.key - dsvs_pkg::KEY_OFS_B;
            key_hit = 1'b1;
        end
        key_hit = key_hit && (32'(key_v) < VOICES);
    end

    assign load_hit = 32'(i_cmd.vidx) < VOICES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stp   <= STP_SQ;
            r_vc    <= '0;
            for (int i = 0; i < VOICES; i++) begin
                r_vol[i] <= '0;
                r_ph[i]  <= '0;
                r_st[i]  <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        case (i_cmd.op)
                            dsvs_pkg::OP_STRIKE: begin
                                if (key_hit) begin
                                    r_vol[VI_W'(key_v)] <= i_cfg.strike;
                                end
                            end
                            dsvs_pkg::OP_LOAD: begin
                                if (load_hit) begin
                                    r_st[VI_W'(i_cmd.vidx)] <= PHASE_BITS'(i_cmd.step);
                                end
                            end
                            dsvs_pkg::OP_TICK: begin
                                r_state <= ST_RUN;
                                r_stp   <= STP_SQ;
                                r_vc    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    r_stp <= r_stp + 3'd1;
                    if (r_stp == STP_WB) begin
                        r_vol[r_vc] <= (nv < i_cfg.floor_lvl) ? '0 : nv;
                        r_ph[r_vc]  <= cur_ph + cur_st;
                        if (r_vc == LAST_V) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_vc <= r_vc + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (i_smp_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if (r_state == ST_RUN) begin
            case (r_stp)
                STP_SQ: begin
                    r_x   <= x;
                    r_neg <= t[15];
                end
                STP_P1: begin
                    r_x2 <= q14[14:0];
                end
                STP_DECAY: begin
                    r_acc <= r_neg ? (r_acc - term_s) : (r_acc + term_s);
                end
                default: begin
                end
            endcase
        end
    end

    assign acc64 = 64'(r_acc);
    always_comb begin
        if (acc64 > 64'sh7FFFFFFF) begin
            sat = 32'h7FFFFFFF;
        end else if (acc64 < -64'sh80000000) begin
            sat = 32'h80000000;
        end else begin
            sat = acc64[31:0];
        end
    end

    assign o_stat.busy      = (r_state != ST_IDLE);
    assign o_stat.smp_valid = (r_state == ST_DONE);
    assign o_stat.sample    = sat;

    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid |-> r_state == ST_IDLE)
        else $error("command while sequencer busy");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_stp == STP_WB && r_vc == LAST_V) |=> r_state == ST_DONE)
        else $error("last voice did not finish the sample");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_smp_ready) |=> (r_state == ST_DONE && $stable(r_acc)))
        else $error("sample lost while output stalled");

    a_vc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> 32'(r_vc) < VOICES)
        else $error("voice counter out of range");

endmodule
